@@ rtl/core/wpo_pkg.sv @@
`timescale 1ns / 1ps
package wpo_pkg;

    localparam int WHEELS_DEFAULT = 2;
    localparam int WHEEL_W        = 3;
    localparam int OP_W           = 3;
    localparam int COUNT_W        = 8;
    localparam int DIR_W          = 2;
    localparam int MAG_W          = 8;
    localparam int CIRC_W         = 24;
    localparam int SPEED_W        = 32;
    localparam int DIST_W         = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 24;
    localparam int IN_DATA_W      = 16;
    localparam int OUT_DATA_W     = 112;
    localparam int DIV_STEPS      = COUNT_W;
    localparam int STEP_W         = $clog2(DIV_STEPS);

    localparam logic [MAG_W-1:0]  MAG_RESET  = 8'd4;
    localparam logic [CIRC_W-1:0] CIRC_RESET = 24'd14418;

    // operation codes
    localparam logic [OP_W-1:0] OP_PULSE_UP   = 3'd0;
    localparam logic [OP_W-1:0] OP_PULSE_DOWN = 3'd1;
    localparam logic [OP_W-1:0] OP_SET        = 3'd2;
    localparam logic [OP_W-1:0] OP_RESET      = 3'd3;
    localparam logic [OP_W-1:0] OP_RESET_ALL  = 3'd4;
    localparam logic [OP_W-1:0] OP_TICK       = 3'd5;

    // travel direction codes
    localparam logic [DIR_W-1:0] DIR_FORWARD  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_BACKWARD = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAGNETS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRC    = 2'd1;

    typedef struct packed {
        logic               latch_item;
        logic               exec_op;
        logic               div_load;
        logic               div_step;
        logic               mul_en;
        logic               acc_en;
        logic [WHEEL_W-1:0] wheel;
    } cmd_t;

    typedef struct packed {
        logic op_is_tick;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/core/wpo_ctrl.sv @@
`timescale 1ns / 1ps
module wpo_ctrl #(
    parameter int WHEELS = wpo_pkg::WHEELS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_valid,
    output logic          s_ready,
    input  wpo_pkg::sts_t sts,
    output wpo_pkg::cmd_t cmd
);
    import wpo_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;

    localparam logic [WHEEL_W-1:0] LAST_WHEEL = WHEEL_W'(WHEELS - 1);
    localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(DIV_STEPS - 1);

    logic [2:0]         state_reg, state_next;
    logic [WHEEL_W-1:0] wheel_reg, wheel_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wheel_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wheel_reg <= wheel_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        wheel_next     = wheel_reg;
        step_next      = step_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.wheel      = wheel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec_op = 1'b1;
                wheel_next  = '0;
                state_next  = sts.op_is_tick ? S_LOAD : S_IDLE;
            end
            S_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (sts.out_free)
                begin
                    cmd.acc_en = 1'b1;
                    if (wheel_reg == LAST_WHEEL)
                        state_next = S_IDLE;
                    else
                    begin
                        wheel_next = wheel_reg + 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && step_reg == LAST_STEP |=> state_reg == S_MUL)
        else $error("divide phase length wrong");

    a_tick_walks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC && sts.op_is_tick |=> state_reg == S_LOAD && wheel_reg == '0)
        else $error("tick did not start at first wheel");

    a_wheel_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE && state_reg != S_EXEC |-> wheel_reg <= LAST_WHEEL)
        else $error("wheel iterator out of range");

endmodule

@@ rtl/core/wpo_datapath.sv @@
`timescale 1ns / 1ps
module wpo_datapath #(
    parameter int WHEELS = wpo_pkg::WHEELS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wpo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wpo_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [wpo_pkg::OP_W-1:0]         in_op,
    input  logic [wpo_pkg::WHEEL_W-1:0]      in_wheel,
    input  logic [wpo_pkg::COUNT_W-1:0]      in_count,
    input  logic [wpo_pkg::DIR_W-1:0]        in_dir,
    input  wpo_pkg::cmd_t                    cmd,
    output wpo_pkg::sts_t                    sts,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [wpo_pkg::WHEEL_W-1:0]      out_wheel,
    output logic [wpo_pkg::COUNT_W-1:0]      out_revs,
    output logic [wpo_pkg::SPEED_W-1:0]      out_speed,
    output logic [wpo_pkg::DIST_W-1:0]       out_fwd,
    output logic [wpo_pkg::DIST_W-1:0]       out_bwd,
    output logic                             out_last
);
    import wpo_pkg::*;

    localparam int WIDX = (WHEELS > 1) ? $clog2(WHEELS) : 1;
    localparam logic [WHEEL_W-1:0] LAST_WHEEL = WHEEL_W'(WHEELS - 1);

    logic [MAG_W-1:0]   mag_reg;
    logic [CIRC_W-1:0]  circ_reg;
    logic [COUNT_W-1:0] pulse_reg [WHEELS];
    logic [DIST_W-1:0]  fwd_reg   [WHEELS];
    logic [DIST_W-1:0]  bwd_reg   [WHEELS];

    logic [OP_W-1:0]    op_reg;
    logic [WHEEL_W-1:0] wheel_item_reg;
    logic [COUNT_W-1:0] count_item_reg;
    logic [DIR_W-1:0]   dir_reg;

    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] quo_reg, quo_next;
    logic [COUNT_W-1:0] revs_reg;
    logic [SPEED_W-1:0] prod_reg;
    logic               out_valid_reg;

    logic [WHEEL_W-1:0] wheel_clamped;
    logic [WHEEL_W-1:0] sel_wheel;
    logic [WIDX-1:0]    addr;
    logic [COUNT_W:0]   shifted;
    logic [COUNT_W:0]   trial;
    logic [DIST_W-1:0]  meters;
    logic [DIST_W-1:0]  fwd_sum;
    logic [DIST_W-1:0]  bwd_sum;
    logic [COUNT_W-1:0] revs_val;

    assign wheel_clamped = ({1'b0, wheel_item_reg} >= (WHEEL_W+1)'(WHEELS)) ?
                           LAST_WHEEL : wheel_item_reg;
    assign sel_wheel     = cmd.exec_op ? wheel_clamped : cmd.wheel;
    assign addr          = sel_wheel[WIDX-1:0];

    // one restoring step per cycle, quotient bits shift in from the bottom
    assign shifted  = {rem_reg, quo_reg[COUNT_W-1]};
    assign trial    = shifted - {1'b0, mag_reg};
    assign rem_next = trial[COUNT_W] ? shifted[COUNT_W-1:0] : trial[COUNT_W-1:0];
    assign quo_next = {quo_reg[COUNT_W-2:0], ~trial[COUNT_W]};

    assign revs_val = (mag_reg == '0) ? '0 : quo_reg;

    // integer meters of the speed, fraction dropped
    assign meters  = {16'd0, prod_reg[SPEED_W-1:16]};
    assign fwd_sum = fwd_reg[addr] + meters;
    assign bwd_sum = bwd_reg[addr] + meters;

    assign sts.op_is_tick = (op_reg == OP_TICK);
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg       <= MAG_RESET;
            circ_reg      <= CIRC_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WHEELS; i++)
            begin
                pulse_reg[i] <= '0;
                fwd_reg[i]   <= '0;
                bwd_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MAGNETS)
                    mag_reg <= cfg_data[MAG_W-1:0];
                else if (cfg_index == CFG_CIRC)
                    circ_reg <= cfg_data[CIRC_W-1:0];
            end

            if (cmd.exec_op)
            begin
                unique case (op_reg)
                    OP_PULSE_UP:   pulse_reg[addr] <= pulse_reg[addr] + 1'b1;
                    OP_PULSE_DOWN: pulse_reg[addr] <= pulse_reg[addr] - 1'b1;
                    OP_SET:        pulse_reg[addr] <= count_item_reg;
                    OP_RESET:
                    begin
                        pulse_reg[addr] <= '0;
                        fwd_reg[addr]   <= '0;
                        bwd_reg[addr]   <= '0;
                    end
                    OP_RESET_ALL:
                    begin
                        for (int i = 0; i < WHEELS; i++)
                        begin
                            pulse_reg[i] <= '0;
                            fwd_reg[i]   <= '0;
                            bwd_reg[i]   <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.acc_en)
            begin
                pulse_reg[addr] <= '0;
                if (dir_reg == DIR_FORWARD)
                    fwd_reg[addr] <= fwd_sum;
                else if (dir_reg == DIR_BACKWARD)
                    bwd_reg[addr] <= bwd_sum;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            op_reg         <= in_op;
            wheel_item_reg <= in_wheel;
            count_item_reg <= in_count;
            dir_reg        <= in_dir;
        end
        if (cmd.div_load)
        begin
            rem_reg <= '0;
            quo_reg <= pulse_reg[addr];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.mul_en)
        begin
            revs_reg <= revs_val;
            // 8 x 24 bits, both widened so the full product is kept
            prod_reg <= {{(SPEED_W-COUNT_W){1'b0}}, revs_val} *
                        {{(SPEED_W-CIRC_W){1'b0}}, circ_reg};
        end
        if (cmd.acc_en)
        begin
            out_wheel <= sel_wheel;
            out_revs  <= revs_reg;
            out_speed <= prod_reg;
            out_fwd   <= (dir_reg == DIR_FORWARD)  ? fwd_sum : fwd_reg[addr];
            out_bwd   <= (dir_reg == DIR_BACKWARD) ? bwd_sum : bwd_reg[addr];
            out_last  <= (sel_wheel == LAST_WHEEL);
        end
    end

    a_acc_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_en |-> sts.out_free)
        else $error("result written over a pending one");

    a_zero_magnets: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_en && mag_reg == '0 |=> out_revs == '0 && out_speed == '0)
        else $error("zero magnets gave nonzero speed");

    a_acc_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_en |=> out_valid_reg && pulse_reg[$past(addr)] == '0)
        else $error("tick did not clear counter or raise result");

endmodule

@@ rtl/core/wheel_pulse_odometer_unit.sv @@
`timescale 1ns / 1ps
// Sequence: pulse/set/reset ops are accepted, then executed; a tick is accepted, executed,
// then each wheel in turn takes load, 8 divide steps, multiply and accumulate.
// Flow: one item in flight; a tick holds the input through all wheels and any output stalls,
// mostly in the bit-serial divider. A waiting result stalls only the next accumulate.
// Reset (rst_n, async, active low): counters and totals zero, magnets 4, circumference 14418.
module wheel_pulse_odometer_unit #(
    parameter int WHEELS = wpo_pkg::WHEELS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [wpo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wpo_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: op[2:0], wheel_index[5:3], counter_value[13:6], direction[15:14]
    input  logic [wpo_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: result_wheel[2:0], revs_per_second[10:3], speed_q16[42:11],
    //        distance_forward[74:43], distance_backward[106:75], zero pad[111:107]
    output logic [wpo_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // tlast: last_wheel
    output logic                             m_axis_tlast
);
    import wpo_pkg::*;

    cmd_t               cmd;
    sts_t               sts;
    logic [WHEEL_W-1:0] out_wheel;
    logic [COUNT_W-1:0] out_revs;
    logic [SPEED_W-1:0] out_speed;
    logic [DIST_W-1:0]  out_fwd;
    logic [DIST_W-1:0]  out_bwd;

    // Sequencer: accepts one transaction, then walks the wheels on a tick.
    wpo_ctrl #(
        .WHEELS (WHEELS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Per-wheel state, divider, multiplier and result register.
    wpo_datapath #(
        .WHEELS (WHEELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_axis_tdata[2:0]),
        .in_wheel  (s_axis_tdata[5:3]),
        .in_count  (s_axis_tdata[13:6]),
        .in_dir    (s_axis_tdata[15:14]),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_wheel (out_wheel),
        .out_revs  (out_revs),
        .out_speed (out_speed),
        .out_fwd   (out_fwd),
        .out_bwd   (out_bwd),
        .out_last  (m_axis_tlast)
    );

    // pack result fields, lowest first, zero filled to a byte boundary
    assign m_axis_tdata = {5'd0, out_bwd, out_fwd, out_speed, out_revs, out_wheel};

endmodule
